// ----- rtl/mreu_pkg.sv -----
`default_nettype none

package mreu_pkg;

  localparam int XLEN          = 32;
  localparam int PC_W          = 12;
  localparam int REG_IDX_W     = 5;
  localparam int OP_W          = 4;
  localparam int MEM_WORDS_DEF = 4096;
  localparam int NUM_REGS_DEF  = 32;
  localparam int OUTQ_DEPTH    = 4;
  localparam int RECIP_W       = 14;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_ADDI = 4'd2,
    OP_BNE  = 4'd3,
    OP_BLT  = 4'd4,
    OP_BEQ  = 4'd5,
    OP_LW   = 4'd6,
    OP_SW   = 4'd7,
    OP_J    = 4'd8,
    OP_JAL  = 4'd9,
    OP_LA   = 4'd10,
    OP_LI   = 4'd11,
    OP_NOP  = 4'd12
  } opcode_t;

  typedef struct packed {
    logic [PC_W-1:0]      next_pc;
    logic                 branch_taken;
    logic                 reg_write;
    logic [REG_IDX_W-1:0] write_reg;
    logic [XLEN-1:0]      write_value;
    logic                 mem_fault;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/mini_risc_execute_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake                  Payload
// instr     in   instr_valid/instr_ready    opcode dest_reg src_a src_b immediate target_addr
// result    out  result_valid/result_ready  next_pc branch_taken reg_write write_reg
//                                           write_value mem_fault
// cfg       in   cfg_we                     cfg_wdata (start_pc, reloads pc)
//
// One instruction per cycle while instr_ready is high. Register file and data memory
// are synchronous RAMs with registered reads: an instruction reads registers on accept,
// executes and accesses data memory in the next cycle, and writes back the cycle after
// that, with forwarding from write-back and from the previous write into execute.
// Results are queued in a 4-beat buffer; instr_ready drops when it may fill.
// After reset a clearing pass over all MEM_WORDS words resets the word valid bits;
// no instruction is accepted during it.

module mini_risc_execute_unit #(
  parameter int MEM_WORDS = mreu_pkg::MEM_WORDS_DEF,
  parameter int NUM_REGS  = mreu_pkg::NUM_REGS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             instr_valid,
  output logic                                  instr_ready,
  input  wire logic [mreu_pkg::OP_W-1:0]        opcode,
  input  wire logic [mreu_pkg::REG_IDX_W-1:0]   dest_reg,
  input  wire logic [mreu_pkg::REG_IDX_W-1:0]   src_a,
  input  wire logic [mreu_pkg::REG_IDX_W-1:0]   src_b,
  input  wire logic signed [mreu_pkg::XLEN-1:0] immediate,
  input  wire logic [mreu_pkg::PC_W-1:0]        target_addr,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [mreu_pkg::PC_W-1:0]             next_pc,
  output logic                                  branch_taken,
  output logic                                  reg_write,
  output logic [mreu_pkg::REG_IDX_W-1:0]        write_reg,
  output logic signed [mreu_pkg::XLEN-1:0]      write_value,
  output logic                                  mem_fault,
  input  wire logic                             cfg_we,
  input  wire logic [mreu_pkg::PC_W-1:0]        cfg_wdata
);

  import mreu_pkg::*;

  localparam int AW     = $clog2(MEM_WORDS);
  localparam int REG_AW = $clog2(NUM_REGS);
  localparam int RS     = PC_W + AW;
  localparam longint unsigned RECIP =
    ((longint'(1) << RS) + longint'(MEM_WORDS) - 1) / longint'(MEM_WORDS);
  localparam logic [XLEN-1:0]    RECIP32 = XLEN'(RECIP[RECIP_W-1:0]);
  localparam logic [XLEN-1:0]    MW32    = XLEN'(MEM_WORDS);
  localparam logic [16:0]        MW17    = 17'(MEM_WORDS);
  localparam logic [REG_IDX_W:0] NREG    = (REG_IDX_W+1)'(NUM_REGS);
  localparam logic [AW-1:0]      CLR_END = AW'(MEM_WORDS - 1);
  localparam int QW = $clog2(OUTQ_DEPTH);

  // exact floor(v / MEM_WORDS) for 12-bit v
  function automatic logic [PC_W-1:0] quot_pc(input logic [PC_W-1:0] v);
    logic [XLEN-1:0] prod;
    prod = XLEN'(v) * RECIP32;
    return PC_W'(prod >> RS);
  endfunction

  function automatic logic [PC_W-1:0] rem_pc(input logic [PC_W-1:0] v,
                                            input logic [PC_W-1:0] q);
    logic [XLEN-1:0] r;
    r = XLEN'(v) - XLEN'(q) * MW32;
    return r[PC_W-1:0];
  endfunction

  // storage
  logic [XLEN-1:0] rf [NUM_REGS];
  logic [XLEN:0]   dmem [MEM_WORDS];
  logic [NUM_REGS-1:0] rf_valid;

  // control
  logic            clearing;
  logic [AW-1:0]   clr_addr;
  logic [PC_W-1:0] pc;
  logic            cfg_pend;
  logic [PC_W-1:0] cfg_val;
  logic [PC_W-1:0] cfg_q;

  // execute stage
  logic                 s1_valid;
  opcode_t              s1_op;
  logic [REG_IDX_W-1:0] s1_rd;
  logic [REG_IDX_W-1:0] s1_ra;
  logic [REG_IDX_W-1:0] s1_rb;
  logic [XLEN-1:0]      s1_imm;
  logic [PC_W-1:0]      s1_tgt;
  logic [PC_W-1:0]      s1_tq;
  logic [XLEN-1:0]      rf_qa;
  logic [XLEN-1:0]      rf_qb;

  // write-back stage
  logic    s2_valid;
  logic    s2_lw;
  result_t s2_res;
  logic [XLEN:0] dm_q;

  // previous write-back, for RAM read-during-write
  logic                 fw_en;
  logic [REG_IDX_W-1:0] fw_idx;
  logic [XLEN-1:0]      fw_val;

  // result queue
  result_t          outq [OUTQ_DEPTH];
  logic [QW-1:0]    wp;
  logic [QW-1:0]    rp;
  logic [QW:0]      q_cnt;

  logic [QW:0] inflight;
  logic        accept;
  logic        pop;

  assign inflight    = q_cnt + (QW+1)'(s1_valid) + (QW+1)'(s2_valid);
  assign instr_ready = !clearing && (inflight < (QW+1)'(OUTQ_DEPTH));
  assign accept      = instr_valid && instr_ready;
  assign pop         = result_valid && result_ready;

  // write-back
  logic            wr2;
  logic [XLEN-1:0] wval2;
  result_t         fin;

  always_comb begin
    wr2   = s2_valid && (s2_lw ? dm_q[XLEN] : s2_res.reg_write);
    wval2 = s2_lw ? dm_q[XLEN-1:0] : s2_res.write_value;
    fin              = s2_res;
    fin.reg_write    = wr2;
    fin.write_reg    = wr2 ? s2_res.write_reg : '0;
    fin.write_value  = wr2 ? wval2 : '0;
  end

  function automatic logic [XLEN-1:0] src_val(
    input logic [REG_IDX_W-1:0] idx, input logic [XLEN-1:0] ram_q,
    input logic wb_en, input logic [REG_IDX_W-1:0] wb_idx, input logic [XLEN-1:0] wb_val,
    input logic f_en, input logic [REG_IDX_W-1:0] f_idx, input logic [XLEN-1:0] f_val,
    input logic [NUM_REGS-1:0] vld);
    if ({1'b0, idx} >= NREG)
      return '0;
    else if (wb_en && wb_idx == idx)
      return wb_val;
    else if (f_en && f_idx == idx)
      return f_val;
    else if (vld[idx[REG_AW-1:0]])
      return ram_q;
    else
      return '0;
  endfunction

  // execute
  logic [XLEN-1:0] va;
  logic [XLEN-1:0] vb;
  logic [PC_W:0]   pc_p1;
  logic [PC_W-1:0] seq_pc;
  logic [PC_W-1:0] tgt_wrap;
  logic [XLEN-1:0] addr;
  logic            fault;
  logic            taken;
  logic            wr1;
  logic [XLEN-1:0] wval1;
  logic            is_ld;
  logic            is_st;
  logic            rd_ok;
  logic [PC_W-1:0] npc;

  always_comb begin
    va = src_val(s1_ra, rf_qa, wr2, s2_res.write_reg, wval2, fw_en, fw_idx, fw_val, rf_valid);
    vb = src_val(s1_rb, rf_qb, wr2, s2_res.write_reg, wval2, fw_en, fw_idx, fw_val, rf_valid);
    pc_p1    = {1'b0, pc} + (PC_W+1)'(1);
    seq_pc   = ((17'(pc_p1)) == MW17) ? '0 : pc_p1[PC_W-1:0];
    tgt_wrap = rem_pc(s1_tgt, s1_tq);
    addr     = va + s1_imm;
    fault    = 1'b0;
    taken    = 1'b0;
    wr1      = 1'b0;
    wval1    = '0;
    is_ld    = 1'b0;
    is_st    = 1'b0;
    case (s1_op)
      OP_ADD:  begin wr1 = 1'b1; wval1 = va + vb; end
      OP_SUB:  begin wr1 = 1'b1; wval1 = va - vb; end
      OP_ADDI: begin wr1 = 1'b1; wval1 = va + s1_imm; end
      OP_BNE:  taken = (va != vb);
      OP_BLT:  taken = ($signed(va) < $signed(vb));
      OP_BEQ:  taken = (va == vb);
      OP_LW:   begin fault = (addr >= MW32); is_ld = !fault; end
      OP_SW:   begin fault = (addr >= MW32); is_st = !fault; end
      OP_J:    taken = 1'b1;
      OP_JAL:  begin taken = 1'b1; wr1 = 1'b1; wval1 = XLEN'(seq_pc); end
      OP_LA:   begin wr1 = 1'b1; wval1 = XLEN'(s1_tgt); end
      OP_LI:   begin wr1 = 1'b1; wval1 = s1_imm; end
      default: ;
    endcase
    rd_ok = ({1'b0, s1_rd} < NREG);
    npc   = taken ? tgt_wrap : seq_pc;
  end

  // register file RAM
  always_ff @(posedge clk) begin
    if (wr2)
      rf[s2_res.write_reg[REG_AW-1:0]] <= wval2;
    rf_qa <= rf[src_a[REG_AW-1:0]];
    rf_qb <= rf[src_b[REG_AW-1:0]];
  end

  // data memory RAM, bit XLEN marks a written word
  logic [AW-1:0] dm_addr;
  logic          dm_we;
  logic [XLEN:0] dm_wdata;

  always_comb begin
    dm_addr  = clearing ? clr_addr : addr[AW-1:0];
    dm_we    = clearing || (s1_valid && is_st);
    dm_wdata = clearing ? '0 : {1'b1, vb};
  end

  always_ff @(posedge clk) begin
    if (dm_we)
      dmem[dm_addr] <= dm_wdata;
    dm_q <= dmem[dm_addr];
  end

  // control and pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      pc       <= '0;
      cfg_pend <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fw_en    <= 1'b0;
      rf_valid <= '0;
      wp       <= '0;
      rp       <= '0;
      q_cnt    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == CLR_END)
          clearing <= 1'b0;
      end

      cfg_pend <= cfg_we;
      if (cfg_pend)
        pc <= rem_pc(cfg_val, cfg_q);
      else if (s1_valid)
        pc <= npc;

      s1_valid <= accept;
      s2_valid <= s1_valid;

      fw_en <= wr2;
      if (wr2)
        rf_valid[s2_res.write_reg[REG_AW-1:0]] <= 1'b1;

      if (s2_valid)
        wp <= wp + QW'(1);
      if (pop)
        rp <= rp + QW'(1);
      q_cnt <= q_cnt + (QW+1)'(s2_valid) - (QW+1)'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cfg_we) begin
      cfg_val <= cfg_wdata;
      cfg_q   <= quot_pc(cfg_wdata);
    end
    if (accept) begin
      s1_op  <= opcode_t'(opcode);
      s1_rd  <= dest_reg;
      s1_ra  <= src_a;
      s1_rb  <= src_b;
      s1_imm <= immediate;
      s1_tgt <= target_addr;
      s1_tq  <= quot_pc(target_addr);
    end
    s2_lw                <= is_ld && rd_ok;
    s2_res.next_pc       <= npc;
    s2_res.branch_taken  <= taken;
    s2_res.reg_write     <= wr1 && rd_ok;
    s2_res.write_reg     <= s1_rd;
    s2_res.write_value   <= wval1;
    s2_res.mem_fault     <= fault;
    fw_idx <= s2_res.write_reg;
    fw_val <= wval2;
    if (s2_valid)
      outq[wp] <= fin;
  end

  assign result_valid = (q_cnt != '0);
  assign next_pc      = outq[rp].next_pc;
  assign branch_taken = outq[rp].branch_taken;
  assign reg_write    = outq[rp].reg_write;
  assign write_reg    = outq[rp].write_reg;
  assign write_value  = outq[rp].write_value;
  assign mem_fault    = outq[rp].mem_fault;

endmodule

`default_nettype wire
